### src/nvf_pkg.sv
// ----------------------------------------------------------------------------
// nvf_pkg: shared types and codes for the number-to-voice fragment block
// Item and fragment payload structs, action codes and fragment codes.
// ----------------------------------------------------------------------------
`default_nettype none

package nvf_pkg;

  localparam int unsigned VALUE_W = 24;
  localparam int unsigned FRAG_W  = 5;
  localparam int unsigned NUM_BCD = 7;

  localparam logic [1:0] ACT_AMOUNT  = 2'd0;
  localparam logic [1:0] ACT_INTEGER = 2'd1;
  localparam logic [1:0] ACT_PORT    = 2'd2;
  localparam logic [1:0] ACT_UNUSED  = 2'd3;

  localparam logic [FRAG_W-1:0] FR_ZERO = 5'd0;
  localparam logic [FRAG_W-1:0] FR_TEN  = 5'd10;
  localparam logic [FRAG_W-1:0] FR_DOT  = 5'd14;
  localparam logic [FRAG_W-1:0] FR_YUAN = 5'd15;
  localparam logic [FRAG_W-1:0] FR_NO   = 5'd16;
  localparam logic [FRAG_W-1:0] FR_PORT = 5'd17;

  localparam logic [VALUE_W-1:0] INT_MAX  = 24'd99999;
  localparam logic [VALUE_W-1:0] CENT_MAX = 24'd9999999;

  typedef struct packed {
    logic [1:0]         action;
    logic [VALUE_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic [FRAG_W-1:0] fragment;
    logic              last;
  } frag_t;

endpackage

`default_nettype wire

### src/number_to_voice_fragments_top.sv
// ----------------------------------------------------------------------------
// number_to_voice_fragments_top: number to spoken fragment sequencer
// Converts an amount, integer or port number to decimal with a bit-serial
// shift-and-add-3 converter, then walks the digits and emits fragment codes.
// ----------------------------------------------------------------------------
// An item passes the bit-serial binary to BCD conversion, a setup step and a digit
// step before its first fragment; for ten to nineteen the leading one is dropped.
// Items are taken one at a time: an item is held until its digit positions and tail
// fragments are out, and output stalls hold it longer; an unused action is accepted
// and dropped. Fragments leave at up to one per cycle while frag_ready allows.
// Reset (rst, synchronous) returns the sequencer to idle and drops any fragment.
`default_nettype none

module number_to_voice_fragments_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          item_valid,
  output logic               item_ready,
  input  wire nvf_pkg::item_t item,
  output logic               frag_valid,
  input  wire logic          frag_ready,
  output nvf_pkg::frag_t     frag
);
  import nvf_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_TOP  = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  localparam logic [2:0] T_DOT  = 3'd0;
  localparam logic [2:0] T_C1   = 3'd1;
  localparam logic [2:0] T_C0   = 3'd2;
  localparam logic [2:0] T_YUAN = 3'd3;
  localparam logic [2:0] T_NO   = 3'd4;
  localparam logic [2:0] T_PORT = 3'd5;

  localparam logic PH_DIG  = 1'b0;
  localparam logic PH_UNIT = 1'b1;

  localparam int unsigned CNT_W = $clog2(VALUE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

  logic [2:0]           state;
  logic [CNT_W-1:0]     cnt;
  logic [VALUE_W-1:0]   bin;
  logic [4*NUM_BCD-1:0] bcd;
  logic [1:0]           act;
  logic [2:0]           pos;
  logic                 ph;
  logic                 zp;
  logic [2:0]           tstep;

  logic [VALUE_W-1:0]   sat_value;
  logic [4*NUM_BCD-1:0] bcd_adj;
  logic [3:0]           ipd [5];
  logic [4:0]           lownz;
  logic [2:0]           top;
  logic [3:0]           d;
  logic [3:0]           c1;
  logic [3:0]           c0;
  logic                 is_int;
  logic                 adv;
  logic                 emit;
  frag_t                emit_frag;
  logic [2:0]           state_next;
  logic [2:0]           pos_next;
  logic                 ph_next;
  logic                 zp_next;
  logic [2:0]           tstep_next;

  assign item_ready = (state == S_IDLE) && !rst;
  assign adv        = !frag_valid || frag_ready;
  assign is_int     = (act == ACT_INTEGER);
  assign c1         = bcd[7:4];
  assign c0         = bcd[3:0];

  always_comb begin
    if (item.action == ACT_AMOUNT) begin
      sat_value = (item.value > CENT_MAX) ? CENT_MAX : item.value;
    end else begin
      sat_value = (item.value > INT_MAX) ? INT_MAX : item.value;
    end
  end

  // add 3 to each BCD digit of 5 or more before the shift
  always_comb begin
    for (int k = 0; k < NUM_BCD; k++) begin
      if (bcd[4*k +: 4] >= 4'd5) begin
        bcd_adj[4*k +: 4] = bcd[4*k +: 4] + 4'd3;
      end else begin
        bcd_adj[4*k +: 4] = bcd[4*k +: 4];
      end
    end
  end

  // integer digits: yuan digits for an amount, plain digits otherwise
  always_comb begin
    for (int k = 0; k < 5; k++) begin
      ipd[k] = (act == ACT_AMOUNT) ? bcd[4*(k+2) +: 4] : bcd[4*k +: 4];
    end
    lownz[0] = 1'b0;
    for (int k = 1; k < 5; k++) begin
      lownz[k] = lownz[k-1] || (ipd[k-1] != 4'd0);
    end
    top = 3'd0;
    for (int k = 1; k < 5; k++) begin
      if (ipd[k] != 4'd0) begin
        top = 3'(k);
      end
    end
  end

  assign d = ipd[pos];

  always_comb begin
    state_next = state;
    pos_next   = pos;
    ph_next    = ph;
    zp_next    = zp;
    tstep_next = tstep;
    emit       = 1'b0;
    emit_frag  = '{fragment: FR_ZERO, last: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (item_valid) begin
          state_next = (item.action == ACT_AMOUNT || item.action == ACT_INTEGER ||
                        item.action == ACT_PORT) ? S_CONV : S_IDLE;
        end
      end
      S_CONV: begin
        if (cnt == CNT_LAST) begin
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        pos_next   = top;
        ph_next    = PH_DIG;
        zp_next    = 1'b0;
        state_next = S_INT;
      end
      S_INT: begin
        if (adv) begin
          logic to_tail;
          to_tail = 1'b0;
          if (ph == PH_UNIT) begin
            emit      = 1'b1;
            emit_frag = '{fragment: FR_TEN + FRAG_W'(pos) - 5'd1,
                          last: is_int && !lownz[pos]};
            pos_next  = pos - 3'd1;
            ph_next   = PH_DIG;
          end else if (d == 4'd0) begin
            if (pos == 3'd0) begin
              if (top == 3'd0) begin
                // the whole integer part is zero: speak a single zero
                emit      = 1'b1;
                emit_frag = '{fragment: FR_ZERO, last: is_int};
              end
              to_tail = 1'b1;
            end else begin
              zp_next  = 1'b1;
              pos_next = pos - 3'd1;
            end
          end else if (zp) begin
            emit      = 1'b1;
            emit_frag = '{fragment: FR_ZERO, last: 1'b0};
            zp_next   = 1'b0;
          end else begin
            // drop the leading one of ten to nineteen
            if (!(top == 3'd1 && pos == 3'd1 && d == 4'd1)) begin
              emit      = 1'b1;
              emit_frag = '{fragment: FRAG_W'(d), last: is_int && pos == 3'd0};
            end
            if (pos == 3'd0) begin
              to_tail = 1'b1;
            end else begin
              ph_next = PH_UNIT;
            end
          end
          if (to_tail) begin
            unique case (act)
              ACT_AMOUNT: begin
                state_next = S_TAIL;
                tstep_next = (c1 != 4'd0 || c0 != 4'd0) ? T_DOT : T_YUAN;
              end
              ACT_PORT: begin
                state_next = S_TAIL;
                tstep_next = T_NO;
              end
              default: begin
                state_next = S_IDLE;
              end
            endcase
          end
        end
      end
      S_TAIL: begin
        if (adv) begin
          emit = 1'b1;
          unique case (tstep)
            T_DOT: begin
              emit_frag  = '{fragment: FR_DOT, last: 1'b0};
              tstep_next = T_C1;
            end
            T_C1: begin
              emit_frag  = '{fragment: FRAG_W'(c1), last: 1'b0};
              tstep_next = (c0 != 4'd0) ? T_C0 : T_YUAN;
            end
            T_C0: begin
              emit_frag  = '{fragment: FRAG_W'(c0), last: 1'b0};
              tstep_next = T_YUAN;
            end
            T_YUAN: begin
              emit_frag  = '{fragment: FR_YUAN, last: 1'b1};
              state_next = S_IDLE;
            end
            T_NO: begin
              emit_frag  = '{fragment: FR_NO, last: 1'b0};
              tstep_next = T_PORT;
            end
            default: begin
              emit_frag  = '{fragment: FR_PORT, last: 1'b1};
              state_next = S_IDLE;
            end
          endcase
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cnt        <= '0;
      pos        <= '0;
      ph         <= PH_DIG;
      zp         <= 1'b0;
      tstep      <= T_DOT;
      frag_valid <= 1'b0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
      ph    <= ph_next;
      zp    <= zp_next;
      tstep <= tstep_next;
      if (state == S_CONV) begin
        cnt <= cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
      if (emit) begin
        frag_valid <= 1'b1;
      end else if (frag_ready) begin
        frag_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && item_valid) begin
      act <= item.action;
      bin <= sat_value;
      bcd <= '0;
    end else if (state == S_CONV) begin
      // shift one binary bit into the BCD digits
      bcd <= {bcd_adj[4*NUM_BCD-2:0], bin[VALUE_W-1]};
      bin <= {bin[VALUE_W-2:0], 1'b0};
    end
    if (emit) begin
      frag <= emit_frag;
    end
  end

  a_conv_exit: assert property (@(posedge clk) disable iff (rst)
    state == S_CONV |=> state == S_CONV || state == S_TOP)
    else $error("conversion left to an unexpected state");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    state == S_INT |-> pos <= 3'd4)
    else $error("digit position out of range");

  a_frag_code: assert property (@(posedge clk) disable iff (rst)
    frag_valid |-> frag.fragment <= FR_PORT)
    else $error("fragment code out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready && item.action != ACT_UNUSED |=> state == S_CONV)
    else $error("accepted item did not start conversion");

endmodule

`default_nettype wire
